// File: rtl/mrc_pkg.sv
// Shared types and constants for the max rod cut pieces block.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package mrc_pkg;

    // Field widths
    localparam int LEN_W     = 12;
    localparam int ENTRY_W   = LEN_W + 1;
    localparam int CFG_IDX_W = 2;

    // Table entry: reach flag on top, piece count below
    localparam logic [ENTRY_W-1:0] ENTRY_REACH = {1'b1, {LEN_W{1'b0}}};
    localparam logic [ENTRY_W-1:0] ENTRY_NONE  = '0;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEG_LEN_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEG_LEN_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEG_LEN_C = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // capture the requested rod length
        logic set_none;   // result is no exact cut
        logic set_empty;  // result is the empty cut
        logic init;       // write entry 0, start the fill at entry 1
        logic issue;      // issue one lookback read and advance
        logic emit;       // load the output register
    } t_mrc_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic over;        // rod longer than the table
        logic zero;        // rod of length 0
        logic last_issue;  // final lookback of the final entry
    } t_mrc_sts;

endpackage

`default_nettype wire

// File: rtl/mrc_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on mrc_pkg for field widths.
`default_nettype none

interface mrc_req_if
    import mrc_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] rod_length;

    modport source(output valid, output rod_length, input ready);
    modport sink(input valid, input rod_length, output ready);
endinterface

interface mrc_rsp_if
    import mrc_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] max_pieces;
    logic             feasible;

    modport source(output valid, output max_pieces, output feasible, input ready);
    modport sink(input valid, input max_pieces, input feasible, output ready);
endinterface

`default_nettype wire

// File: rtl/max_rod_cut_pieces.sv
// Top level of the max rod cut pieces block: controller plus datapath.
// Depends on mrc_pkg, mrc_if, mrc_ctrl and mrc_datapath.
//
// Usage: each request on i_req carries a rod length. The block answers on
// o_rsp with the largest number of pieces that cut the rod exactly using
// the segment lengths in the three configuration registers (index 0..2 on
// i_cfg_*, a length of 0 disables that segment), and a feasible flag.
// For a rod of length n (0 < n <= MAX_LEN) the block fills table entries
// 1 to n, each with three lookback reads on the table memory's read port;
// a zero length or a rod beyond MAX_LEN skips the fill and is answered
// directly. One request is worked on at a time.
// The result sits in an output register, so a new request is taken while
// the previous result still waits; if the receiver stalls, the next result
// waits in its final state until the register frees.
// Reset (synchronous, active low) sets the segment lengths to 1, 0, 0 and
// clears the handshakes; the table needs no clearing pass.

`default_nettype none

module max_rod_cut_pieces
    import mrc_pkg::*;
#(
    parameter int MAX_LEN = 4095
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [LEN_W-1:0]     i_cfg_data,
    mrc_req_if.sink                   i_req,
    mrc_rsp_if.source                 o_rsp
);

    t_mrc_cmd cmd;
    t_mrc_sts sts;

    // Sequence the request through the fill
    mrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Table, lookback merge and result register
    mrc_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_rod_length (i_req.rod_length),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_max_pieces (o_rsp.max_pieces),
        .o_feasible   (o_rsp.feasible)
    );

endmodule

`default_nettype wire

// File: rtl/mrc_datapath.sv
// Datapath: segment length registers, the best count table memory,
// the lookback/merge pipeline and the result register. Depends on mrc_pkg.
`default_nettype none

module mrc_datapath
    import mrc_pkg::*;
#(
    parameter int MAX_LEN = 4095
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [LEN_W-1:0]     i_cfg_data,
    input  wire logic [LEN_W-1:0]     i_rod_length,
    input  wire t_mrc_cmd             i_cmd,
    output t_mrc_sts                  o_sts,
    output logic [LEN_W-1:0]          o_max_pieces,
    output logic                      o_feasible
);

    // Entries beyond the widest rod are never used
    localparam int LEN_MAX_VAL = (1 << LEN_W) - 1;
    localparam int DEPTH = ((MAX_LEN < LEN_MAX_VAL) ? MAX_LEN : LEN_MAX_VAL) + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CMP_W = 17;
    localparam logic [CMP_W-1:0] MaxLenW = CMP_W'(MAX_LEN);

    typedef enum logic [1:0] {PH_A, PH_B, PH_C} t_phase;

    logic [LEN_W-1:0]   r_seg_a;
    logic [LEN_W-1:0]   r_seg_b;
    logic [LEN_W-1:0]   r_seg_c;
    logic [LEN_W-1:0]   r_n;
    logic [LEN_W-1:0]   r_pos;
    t_phase             r_phase;
    logic               r_ret_vld;
    logic               r_ret_first;
    logic               r_ret_last;
    logic [AW-1:0]      r_ret_pos;
    logic               r_slot_vld;
    logic               r_fwd_hit;
    logic [ENTRY_W-1:0] r_fwd_data;
    logic [ENTRY_W-1:0] r_rd_data;
    logic [ENTRY_W-1:0] r_acc;
    logic [LEN_W-1:0]   r_max_pieces;
    logic               r_feasible;
    logic [ENTRY_W-1:0] r_table [DEPTH];

    logic [LEN_W-1:0]   seg;
    logic [LEN_W-1:0]   diff;
    logic [AW-1:0]      rd_addr;
    logic               slot_vld;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [ENTRY_W-1:0] prev;
    logic [ENTRY_W-1:0] base;
    logic [ENTRY_W-1:0] cand;
    logic [ENTRY_W-1:0] merged;
    logic               take;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_a <= LEN_W'(1);
            r_seg_b <= '0;
            r_seg_c <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SEG_LEN_A: r_seg_a <= i_cfg_data;
                CFG_SEG_LEN_B: r_seg_b <= i_cfg_data;
                CFG_SEG_LEN_C: r_seg_c <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Select the segment length for this lookback slot
    always_comb begin
        unique case (r_phase)
            PH_A:    seg = r_seg_a;
            PH_B:    seg = r_seg_b;
            default: seg = r_seg_c;
        endcase
    end

    assign slot_vld = (seg != '0) && (seg <= r_pos);
    assign diff     = r_pos - seg;
    assign rd_addr  = diff[AW-1:0];

    // Merge the returning lookback into the running best for the entry
    assign prev   = r_fwd_hit ? r_fwd_data : r_rd_data;
    assign base   = r_ret_first ? ENTRY_NONE : r_acc;
    assign cand   = {1'b1, prev[LEN_W-1:0] + LEN_W'(1)};
    assign take   = r_slot_vld && prev[LEN_W] &&
                    (!base[LEN_W] || (cand[LEN_W-1:0] > base[LEN_W-1:0]));
    assign merged = take ? cand : base;

    // Table write: entry 0 at start, else each entry after its last lookback
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = ENTRY_REACH;
        priority if (i_cmd.init) begin
            wr_en = 1'b1;
        end else if (r_ret_vld && r_ret_last) begin
            wr_en   = 1'b1;
            wr_addr = r_ret_pos;
            wr_data = merged;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[wr_addr] <= wr_data;
        end
    end

    // Issue lookback reads, forward a same-cycle write of the read entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_data   <= r_table[rd_addr];
            r_ret_first <= (r_phase == PH_A);
            r_ret_last  <= (r_phase == PH_C);
            r_ret_pos   <= r_pos[AW-1:0];
            r_slot_vld  <= slot_vld;
            r_fwd_hit   <= wr_en && (wr_addr == rd_addr);
            r_fwd_data  <= wr_data;
        end
    end

    // Sequence position and phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_A;
            r_ret_vld <= 1'b0;
        end else begin
            r_ret_vld <= i_cmd.issue;
            if (i_cmd.init) begin
                r_phase <= PH_A;
            end else if (i_cmd.issue) begin
                unique case (r_phase)
                    PH_A:    r_phase <= PH_B;
                    PH_B:    r_phase <= PH_C;
                    default: r_phase <= PH_A;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n <= i_rod_length;
        end
        if (i_cmd.init) begin
            r_pos <= LEN_W'(1);
        end else if (i_cmd.issue && (r_phase == PH_C)) begin
            r_pos <= r_pos + LEN_W'(1);
        end
    end

    // Running best for the current entry, or a fixed answer
    always_ff @(posedge i_clk) begin
        if (r_ret_vld) begin
            r_acc <= merged;
        end else if (i_cmd.set_none) begin
            r_acc <= ENTRY_NONE;
        end else if (i_cmd.set_empty) begin
            r_acc <= ENTRY_REACH;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_max_pieces <= r_acc[LEN_W] ? r_acc[LEN_W-1:0] : '0;
            r_feasible   <= r_acc[LEN_W];
        end
    end

    assign o_sts.over       = {{(CMP_W-LEN_W){1'b0}}, r_n} > MaxLenW;
    assign o_sts.zero       = (r_n == '0);
    assign o_sts.last_issue = (r_pos == r_n) && (r_phase == PH_C);
    assign o_max_pieces     = r_max_pieces;
    assign o_feasible       = r_feasible;

endmodule

`default_nettype wire

// File: rtl/mrc_ctrl.sv
// Controller state machine: request handshake, fill sequencing and result
// handshake. Depends on mrc_pkg for the command and status structs.
`default_nettype none

module mrc_ctrl
    import mrc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_req_valid,
    output logic          o_req_ready,
    output logic          o_rsp_valid,
    input  wire logic     i_rsp_ready,
    input  wire t_mrc_sts i_sts,
    output t_mrc_cmd      o_cmd
);

    typedef enum logic [2:0] {ST_IDLE, ST_CHECK, ST_RUN, ST_DRAIN, ST_FINISH} t_state;

    t_state r_state;
    t_state n_state;
    logic   r_rsp_valid;
    logic   n_rsp_valid;
    logic   out_free;

    assign out_free = !r_rsp_valid || i_rsp_ready;

    // Decode commands and next state
    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                priority if (i_sts.over) begin
                    o_cmd.set_none = 1'b1;
                    n_state        = ST_FINISH;
                end else if (i_sts.zero) begin
                    o_cmd.set_empty = 1'b1;
                    n_state         = ST_FINISH;
                end else begin
                    o_cmd.init = 1'b1;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last_issue) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    o_cmd.emit  = 1'b1;
                    n_rsp_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state and the result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_rsp_valid = r_rsp_valid;

endmodule

`default_nettype wire
